FILE: hdl/sql_response_end_tracker_macros.svh
// ----------------------------------------------------------------------------
// sql_response_end_tracker_macros.svh
// Assertion helpers shared by the tracker modules.
// ----------------------------------------------------------------------------
`ifndef SQL_RESPONSE_END_TRACKER_MACROS_SVH
`define SQL_RESPONSE_END_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define SRET_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset.
`define SRET_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sret_pkg.sv
// ----------------------------------------------------------------------------
// sret_pkg
// Types and constants shared by the response end tracker modules.
// ----------------------------------------------------------------------------
package sret_pkg;

    // Default width of the saturating row counter.
    localparam int ROW_COUNT_BITS_DEF = 32;

    // Queue depths between the parts.
    localparam int EVQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    // Event kinds sent from framing to protocol tracking.
    localparam logic [1:0] EV_EMPTY = 2'd0;  // header end of a zero-length packet
    localparam logic [1:0] EV_FIRST = 2'd1;  // first payload byte
    localparam logic [1:0] EV_BODY  = 2'd2;  // any later payload byte

    // Header byte index; HDR_PAYLOAD means inside the payload.
    localparam logic [2:0] HDR_LEN0    = 3'd0;
    localparam logic [2:0] HDR_LEN1    = 3'd1;
    localparam logic [2:0] HDR_LEN2    = 3'd2;
    localparam logic [2:0] HDR_SEQ     = 3'd3;
    localparam logic [2:0] HDR_PAYLOAD = 3'd4;

    // Phases of a response.
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_DEFS  = 2'd1;
    localparam logic [1:0] PH_ROWS  = 2'd2;

    // End kinds.
    localparam logic [2:0] END_EMPTY   = 3'd0;
    localparam logic [2:0] END_OK      = 3'd1;
    localparam logic [2:0] END_ERR     = 3'd2;
    localparam logic [2:0] END_EOF     = 3'd3;
    localparam logic [2:0] END_INFILE  = 3'd4;
    localparam logic [2:0] END_RS_DONE = 3'd5;
    localparam logic [2:0] END_RS_ERR  = 3'd6;

    // Marker bytes.
    localparam logic [7:0] MK_OK     = 8'h00;
    localparam logic [7:0] MK_INFILE = 8'hFB;
    localparam logic [7:0] MK_CNT2   = 8'hFC;
    localparam logic [7:0] MK_CNT3   = 8'hFD;
    localparam logic [7:0] MK_EOF    = 8'hFE;
    localparam logic [7:0] MK_ERR    = 8'hFF;

    // Length-encoded count sizes.
    localparam logic [3:0] CNT_BYTES2 = 4'd2;
    localparam logic [3:0] CNT_BYTES3 = 4'd3;
    localparam logic [3:0] CNT_BYTES8 = 4'd8;

    // Packet length clipped to 4 bits is enough for every length test.
    localparam logic [3:0] LEN_SAT_MAX   = 4'hF;
    localparam logic [3:0] SHORT_EOF_MAX = 4'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;   // last byte of the packet
        logic [3:0] len;    // packet length, saturated
    } t_event;

    typedef struct packed {
        logic [2:0]  end_kind;
        logic [63:0] column_total;
        logic [31:0] row_packet_total;
    } t_result;

endpackage

FILE: hdl/sret_fifo.sv
// ----------------------------------------------------------------------------
// sret_fifo
// Small register queue, first-word fall-through.
// ----------------------------------------------------------------------------
module sret_fifo
    import sret_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: hdl/sret_front.sv
// ----------------------------------------------------------------------------
// sret_front
// Packet framing: strips headers, tags payload bytes as events.
// ----------------------------------------------------------------------------
module sret_front
    import sret_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    output logic       o_full,
    output logic       o_ev_push,
    output t_event     o_ev,
    input  logic       i_ev_full
);

    logic [2:0]  r_hidx, n_hidx;
    logic [23:0] r_plen, n_plen;
    logic [23:0] r_left, n_left;
    logic        w_accept;

    assign o_full   = i_ev_full;
    assign w_accept = i_push && !i_ev_full;

    always_comb begin
        n_hidx      = r_hidx;
        n_plen      = r_plen;
        n_left      = r_left;
        o_ev_push   = 1'b0;
        o_ev.kind   = EV_BODY;
        o_ev.data   = i_data_byte;
        o_ev.last   = 1'b0;
        o_ev.len    = (r_plen > 24'(LEN_SAT_MAX)) ? LEN_SAT_MAX : r_plen[3:0];
        if (w_accept) begin
            if (r_hidx != HDR_PAYLOAD) begin
                unique case (r_hidx)
                    HDR_LEN0: begin
                        n_plen = {16'd0, i_data_byte};
                        n_hidx = HDR_LEN1;
                    end
                    HDR_LEN1: begin
                        n_plen[15:8] = i_data_byte;
                        n_hidx       = HDR_LEN2;
                    end
                    HDR_LEN2: begin
                        n_plen[23:16] = i_data_byte;
                        n_hidx        = HDR_SEQ;
                    end
                    default: begin
                        // sequence byte: ignored, payload starts
                        n_left = r_plen;
                        if (r_plen == '0) begin
                            o_ev_push = 1'b1;
                            o_ev.kind = EV_EMPTY;
                            o_ev.last = 1'b1;
                            n_hidx    = HDR_LEN0;
                        end else begin
                            n_hidx = HDR_PAYLOAD;
                        end
                    end
                endcase
            end else begin
                o_ev_push = 1'b1;
                o_ev.kind = (r_left == r_plen) ? EV_FIRST : EV_BODY;
                o_ev.last = (r_left == 24'd1);
                n_left    = r_left - 1'b1;
                if (r_left == 24'd1) begin
                    n_hidx = HDR_LEN0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx <= HDR_LEN0;
            r_plen <= '0;
            r_left <= '0;
        end else begin
            r_hidx <= n_hidx;
            r_plen <= n_plen;
            r_left <= n_left;
        end
    end

endmodule

FILE: hdl/sret_back.sv
// ----------------------------------------------------------------------------
// sret_back
// Response tracking: phases, column count, row count, end decisions.
// ----------------------------------------------------------------------------
`include "sql_response_end_tracker_macros.svh"

module sret_back
    import sret_pkg::*;
#(
    parameter int ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_ev_valid,
    input  t_event  i_ev,
    output logic    o_ev_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    logic                      r_mode;
    logic [1:0]                r_phase, n_phase;
    logic [7:0]                r_fpb, n_fpb;
    logic [3:0]                r_len, n_len;
    logic [3:0]                r_cnt_need, n_cnt_need;
    logic [3:0]                r_cnt_idx, n_cnt_idx;
    logic [63:0]               r_col, n_col;
    logic [63:0]               r_defs, n_defs;
    logic                      r_pend_vld, n_pend_vld;
    logic [2:0]                r_pend_kind, n_pend_kind;
    logic [ROW_COUNT_BITS-1:0] r_rows, n_rows;
    logic [31:0]               w_rows32;
    logic                      w_short, w_err;

    generate
        if (ROW_COUNT_BITS >= 32) begin : g_rows_wide
            assign w_rows32 = r_rows[31:0];
        end else begin : g_rows_narrow
            assign w_rows32 = {{(32 - ROW_COUNT_BITS){1'b0}}, r_rows};
        end
    endgenerate

    // Marker tests on the packet being classified.
    assign w_short = (n_len != '0) && (n_len <= SHORT_EOF_MAX) && (n_fpb == MK_EOF);
    assign w_err   = (n_len != '0) && (n_fpb == MK_ERR);

    // Packet classification: first byte of a packet (or header of an empty one).
    always_comb begin
        n_fpb       = r_fpb;
        n_len       = r_len;
        if (o_ev_pop && i_ev.kind != EV_BODY) begin
            n_fpb = (i_ev.kind == EV_EMPTY) ? MK_OK : i_ev.data;
            n_len = (i_ev.kind == EV_EMPTY) ? '0 : i_ev.len;
        end
    end

    assign o_ev_pop = i_ev_valid && !i_res_full;

    always_comb begin
        n_phase     = r_phase;
        n_cnt_need  = r_cnt_need;
        n_cnt_idx   = r_cnt_idx;
        n_col       = r_col;
        n_defs      = r_defs;
        n_pend_vld  = r_pend_vld;
        n_pend_kind = r_pend_kind;
        n_rows      = r_rows;
        o_res_push  = 1'b0;
        o_res.end_kind         = r_pend_kind;
        o_res.column_total     = r_col;
        o_res.row_packet_total = w_rows32;
        if (o_ev_pop) begin
            if (i_ev.kind != EV_BODY) begin
                n_pend_vld = 1'b0;
                if (r_phase == PH_DEFS) begin
                    if (!r_mode && !w_short && w_err) begin
                        n_pend_vld  = 1'b1;
                        n_pend_kind = END_RS_ERR;
                    end
                end else if (r_phase == PH_ROWS) begin
                    if (w_err) begin
                        n_pend_vld  = 1'b1;
                        n_pend_kind = END_RS_ERR;
                    end else if (!r_mode ? w_short
                               : (n_len != '0 && (n_fpb == MK_OK || n_fpb == MK_EOF))) begin
                        n_pend_vld  = 1'b1;
                        n_pend_kind = END_RS_DONE;
                    end
                end else begin
                    n_phase    = PH_FIRST;
                    n_col      = '0;
                    n_rows     = '0;
                    n_cnt_need = '0;
                    n_cnt_idx  = '0;
                    n_pend_vld = 1'b1;
                    if (n_len == '0) begin
                        n_pend_kind = END_EMPTY;
                    end else if (n_fpb == MK_OK) begin
                        n_pend_kind = END_OK;
                    end else if (n_fpb == MK_ERR) begin
                        n_pend_kind = END_ERR;
                    end else if (w_short) begin
                        n_pend_kind = END_EOF;
                    end else if (n_fpb == MK_INFILE) begin
                        n_pend_kind = END_INFILE;
                    end else begin
                        n_pend_vld = 1'b0;
                        if (n_fpb < MK_INFILE) begin
                            n_col = {56'd0, n_fpb};
                        end else begin
                            n_cnt_need = (n_fpb == MK_CNT2) ? CNT_BYTES2 :
                                         (n_fpb == MK_CNT3) ? CNT_BYTES3 : CNT_BYTES8;
                            // count bytes must fit after the prefix byte
                            if (n_cnt_need >= n_len) begin
                                n_cnt_need = '0;
                            end
                        end
                    end
                end
            end else if (r_phase == PH_FIRST && r_cnt_idx < r_cnt_need) begin
                for (int k = 0; k < 8; k++) begin
                    if (r_cnt_idx[2:0] == 3'(k)) begin
                        n_col[8*k +: 8] = r_col[8*k +: 8] | i_ev.data;
                    end
                end
                n_cnt_idx = r_cnt_idx + 1'b1;
            end

            // packet end
            if (i_ev.last) begin
                if (n_pend_vld) begin
                    o_res_push             = 1'b1;
                    o_res.end_kind         = n_pend_kind;
                    o_res.column_total     = n_col;
                    // a first-packet end has already cleared the rows
                    o_res.row_packet_total = (r_phase == PH_DEFS || r_phase == PH_ROWS)
                                             ? w_rows32 : '0;
                    n_pend_vld = 1'b0;
                    n_phase    = PH_FIRST;
                    n_col      = '0;
                    n_rows     = '0;
                    n_defs     = '0;
                    n_cnt_need = '0;
                    n_cnt_idx  = '0;
                end else if (n_phase == PH_FIRST) begin
                    n_defs  = n_col;
                    n_phase = (r_mode && n_col == '0) ? PH_ROWS : PH_DEFS;
                end else if (n_phase == PH_DEFS) begin
                    if (!r_mode) begin
                        if (w_short) begin
                            n_phase = PH_ROWS;
                        end
                    end else begin
                        if (r_defs != '0) begin
                            n_defs = r_defs - 1'b1;
                        end
                        if (r_defs == 64'd1 || r_defs == '0) begin
                            n_phase = PH_ROWS;
                        end
                    end
                end else begin
                    if (r_rows != '1) begin
                        n_rows = r_rows + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_phase     <= PH_FIRST;
            r_fpb       <= '0;
            r_len       <= '0;
            r_cnt_need  <= '0;
            r_cnt_idx   <= '0;
            r_col       <= '0;
            r_defs      <= '0;
            r_pend_vld  <= 1'b0;
            r_pend_kind <= END_EMPTY;
            r_rows      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_phase     <= n_phase;
            r_fpb       <= n_fpb;
            r_len       <= n_len;
            r_cnt_need  <= n_cnt_need;
            r_cnt_idx   <= n_cnt_idx;
            r_col       <= n_col;
            r_defs      <= n_defs;
            r_pend_vld  <= n_pend_vld;
            r_pend_kind <= n_pend_kind;
            r_rows      <= n_rows;
        end
    end

    `SRET_ASSERT_IMP(a_cnt_idx_bound, 1'b1, r_cnt_idx <= r_cnt_need, "count index past need")
    `SRET_ASSERT_NXT(a_end_rearms, o_res_push,
        r_phase == PH_FIRST && r_col == '0 && r_rows == '0, "tracker not rearmed after end")
    `SRET_ASSERT_IMP(a_rows_in_row_phase, r_rows != '0, r_phase == PH_ROWS,
        "rows counted outside row phase")

endmodule

FILE: hdl/sql_response_end_tracker.sv
// ----------------------------------------------------------------------------
// sql_response_end_tracker
// Bytes pass the event queue; each result is registered in the result queue.
// Throughput: one byte per cycle, stalled only while the event queue is full.
// Reset: i_rst_n low at a clock edge clears framing, phase, counts, mode, queues.
// ----------------------------------------------------------------------------
//
// Structure:
//   sret_front  - counts header bytes and payload bytes, tags each payload
//                 byte as first / later / last, and flags empty packets.
//   event queue - 4-deep register queue; lets framing run while the back
//                 end waits on a full result queue.
//   sret_back   - classifies packets at their first byte, decodes the
//                 length-encoded column count, walks the definition and
//                 row phases and decides the end of the response.
//   result queue- 2-deep register queue feeding the result ports; results
//                 wait here while the input keeps flowing.
//
// Config: deprecate_eof_mode is written through i_cfg_we / i_cfg_wdata and
// is only expected to change between responses.
module sql_response_end_tracker
    import sret_pkg::*;
#(
    parameter int ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input item side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_end_kind,
    output logic [63:0] o_column_total,
    output logic [31:0] o_row_packet_total
);

    t_event  w_ev_in, w_ev_out;
    logic    w_ev_push, w_ev_full, w_ev_empty, w_ev_pop;
    t_result w_res_in, w_res_out;
    logic    w_res_push, w_res_full;

    // Header stripping and byte tagging.
    sret_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .o_ev_push   (w_ev_push),
        .o_ev        (w_ev_in),
        .i_ev_full   (w_ev_full)
    );

    // Decouples framing from response tracking.
    sret_fifo #(
        .WIDTH ($bits(t_event)),
        .DEPTH (EVQ_DEPTH)
    ) u_ev_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ev_push),
        .i_wdata (w_ev_in),
        .o_full  (w_ev_full),
        .i_pop   (w_ev_pop),
        .o_rdata (w_ev_out),
        .o_empty (w_ev_empty)
    );

    // Phase tracking and end decisions.
    sret_back #(
        .ROW_COUNT_BITS (ROW_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ev_valid  (!w_ev_empty),
        .i_ev        (w_ev_out),
        .o_ev_pop    (w_ev_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Output queue: a waiting result never stalls the byte stream
    // until two results are pending.
    sret_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_out),
        .o_empty (empty)
    );

    assign o_end_kind         = w_res_out.end_kind;
    assign o_column_total     = w_res_out.column_total;
    assign o_row_packet_total = w_res_out.row_packet_total;

endmodule

FILE: tb/sql_response_end_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_response_end_tracker_checker
// Watches the byte and result queues of the tracker, predicts every response
// end from the accepted bytes and compares each popped result field by field.
// ----------------------------------------------------------------------------
module sql_response_end_tracker_checker
    import sret_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_end_kind,
    input  logic [63:0] i_column_total,
    input  logic [31:0] i_row_packet_total,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // predictor state
    logic        mode_q;
    logic [2:0]  hdr_pos;
    logic [23:0] pkt_len;
    logic [23:0] pkt_left;
    logic [1:0]  phase_q;
    logic [7:0]  lead_q;
    logic [3:0]  cnt_need;
    logic [3:0]  cnt_pos;
    logic [63:0] col_cnt;
    logic [63:0] defs_left;
    logic        end_due;
    logic [2:0]  end_code;
    logic [31:0] row_cnt;

    t_result     ends_due[$];

    function automatic bit is_short_eof();
        return pkt_len != 24'd0 && pkt_len <= {20'd0, SHORT_EOF_MAX} && lead_q == MK_EOF;
    endfunction

    function automatic bit is_err();
        return pkt_len != 24'd0 && lead_q == MK_ERR;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // append an expected end to the tail of the queue
    task automatic add_end(input t_result r);
        ends_due.insert(ends_due.size(), r);
    endtask

    // decide at the first payload byte (or header end of an empty packet)
    task automatic judge_packet();
        end_due = 1'b0;
        if (phase_q != PH_DEFS && phase_q != PH_ROWS) begin
            phase_q  = PH_FIRST;
            col_cnt  = '0;
            row_cnt  = '0;
            cnt_need = '0;
            cnt_pos  = '0;
            if (pkt_len == 24'd0) begin
                end_due = 1'b1; end_code = END_EMPTY;
            end else if (lead_q == MK_OK) begin
                end_due = 1'b1; end_code = END_OK;
            end else if (lead_q == MK_ERR) begin
                end_due = 1'b1; end_code = END_ERR;
            end else if (lead_q == MK_EOF && pkt_len <= {20'd0, SHORT_EOF_MAX}) begin
                end_due = 1'b1; end_code = END_EOF;
            end else if (lead_q == MK_INFILE) begin
                end_due = 1'b1; end_code = END_INFILE;
            end else if (lead_q < MK_INFILE) begin
                col_cnt = {56'd0, lead_q};
            end else begin
                cnt_need = (lead_q == MK_CNT2) ? CNT_BYTES2 :
                           (lead_q == MK_CNT3) ? CNT_BYTES3 : CNT_BYTES8;
                // count that does not fit in the packet reads as zero
                if ({20'd0, cnt_need} > pkt_len - 24'd1) cnt_need = '0;
            end
        end else if (phase_q == PH_DEFS) begin
            // deprecate mode only counts definitions
            if (!mode_q && !is_short_eof() && is_err()) begin
                end_due = 1'b1; end_code = END_RS_ERR;
            end
        end else begin
            if (is_err()) begin
                end_due = 1'b1; end_code = END_RS_ERR;
            end else if (!mode_q) begin
                if (is_short_eof()) begin
                    end_due = 1'b1; end_code = END_RS_DONE;
                end
            end else if (pkt_len != 24'd0 && (lead_q == MK_OK || lead_q == MK_EOF)) begin
                end_due = 1'b1; end_code = END_RS_DONE;
            end
        end
    endtask

    // last byte of a packet: emit the end or advance the phase
    task automatic close_packet();
        t_result r;
        hdr_pos = HDR_LEN0;
        if (end_due) begin
            r.end_kind         = end_code;
            r.column_total     = col_cnt;
            r.row_packet_total = row_cnt;
            add_end(r);
            end_due   = 1'b0;
            phase_q   = PH_FIRST;
            col_cnt   = '0;
            row_cnt   = '0;
            defs_left = '0;
            cnt_need  = '0;
            cnt_pos   = '0;
        end else if (phase_q == PH_FIRST) begin
            defs_left = col_cnt;
            phase_q   = (mode_q && col_cnt == 64'd0) ? PH_ROWS : PH_DEFS;
        end else if (phase_q == PH_DEFS) begin
            if (!mode_q) begin
                if (is_short_eof()) phase_q = PH_ROWS;
            end else begin
                if (defs_left != 64'd0) defs_left = defs_left - 64'd1;
                if (defs_left == 64'd0) phase_q = PH_ROWS;
            end
        end else begin
            if (row_cnt != {32{1'b1}}) row_cnt = row_cnt + 32'd1;
        end
    endtask

    task automatic track_byte(input logic [7:0] b);
        if (hdr_pos >= HDR_PAYLOAD && pkt_left == 24'd0) hdr_pos = HDR_LEN0;
        if (hdr_pos < HDR_PAYLOAD) begin
            if (hdr_pos == HDR_LEN0)      pkt_len = {16'd0, b};
            else if (hdr_pos == HDR_LEN1) pkt_len[15:8] = b;
            else if (hdr_pos == HDR_LEN2) pkt_len[23:16] = b;
            // sequence byte is ignored
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == HDR_PAYLOAD) begin
                pkt_left = pkt_len;
                if (pkt_len == 24'd0) begin
                    lead_q = 8'd0;
                    judge_packet();
                    close_packet();
                end
            end
        end else begin
            if (pkt_left == pkt_len) begin
                lead_q = b;
                judge_packet();
            end else if (phase_q == PH_FIRST && cnt_pos < cnt_need) begin
                col_cnt = col_cnt | ({56'd0, b} << (8 * cnt_pos[2:0]));
                cnt_pos = cnt_pos + 4'd1;
            end
            pkt_left = pkt_left - 24'd1;
            if (pkt_left == 24'd0) close_packet();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mode_q       = 1'b0;
            hdr_pos      = HDR_LEN0;
            pkt_len      = '0;
            pkt_left     = '0;
            phase_q      = PH_FIRST;
            lead_q       = '0;
            cnt_need     = '0;
            cnt_pos      = '0;
            col_cnt      = '0;
            defs_left    = '0;
            end_due      = 1'b0;
            end_code     = END_EMPTY;
            row_cnt      = '0;
            o_fail_count = 0;
            o_checked    = 0;
            ends_due.delete();
        end else begin
            // result side first; a new end cannot show in the same cycle
            if (i_pop && !i_empty) begin
                if (ends_due.size() == 0) begin
                    report_mismatch("result with nothing expected, end_kind",
                                    {61'd0, i_end_kind}, 64'd0);
                end else begin
                    want = ends_due.pop_front();
                    o_checked++;
                    if (i_end_kind !== want.end_kind)
                        report_mismatch("end_kind", {61'd0, i_end_kind},
                                        {61'd0, want.end_kind});
                    if (i_column_total !== want.column_total)
                        report_mismatch("column_total", i_column_total, want.column_total);
                    if (i_row_packet_total !== want.row_packet_total)
                        report_mismatch("row_packet_total", {32'd0, i_row_packet_total},
                                        {32'd0, want.row_packet_total});
                end
            end
            // a byte taken at the write edge still sees the old mode
            if (i_push && !i_full) track_byte(i_data_byte);
            if (i_cfg_we) mode_q = i_cfg_wdata;
        end
        o_pending = ends_due.size();
    end

endmodule

FILE: tb/sql_response_end_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_response_end_tracker_tb
// Drives framed server responses into the tracker in both framing modes and
// lets the checker score every reported end; gives the pass/fail verdict.
// ----------------------------------------------------------------------------
module sql_response_end_tracker_tb;
    import sret_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 16;     // covers event queue and result latency
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int TOTAL_BYTES   = 1900;
    localparam int SEG_BYTES     = 320;

    // how the column count is written in the first packet
    typedef enum int {ENC_BYTE, ENC_WORD, ENC_TRIPLE, ENC_QUAD, ENC_CUT} t_enc;
    // how a result set is closed
    typedef enum int {FIN_DONE, FIN_ERR_DEFS, FIN_ERR_ROWS} t_fin;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [2:0]  o_end_kind;
    logic [63:0] o_column_total;
    logic [31:0] o_row_packet_total;

    int          fail_count;
    int          pending;
    int          checked;

    // generator state
    logic        dep_mode    = 1'b0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    int          bytes_sent  = 0;
    int          responses   = 0;
    logic [7:0]  pkt_body[$];

    always #(CLK_HALF) i_clk = ~i_clk;

    sql_response_end_tracker i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .push               (push),
        .full               (full),
        .i_data_byte        (i_data_byte),
        .empty              (empty),
        .pop                (pop),
        .o_end_kind         (o_end_kind),
        .o_column_total     (o_column_total),
        .o_row_packet_total (o_row_packet_total)
    );

    sql_response_end_tracker_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_push             (push),
        .i_full             (full),
        .i_data_byte        (i_data_byte),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_end_kind         (o_end_kind),
        .i_column_total     (o_column_total),
        .i_row_packet_total (o_row_packet_total),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    // result side: pop most cycles, hold off ~16% while idling is on
    always @(negedge i_clk) begin
        pop <= !(rx_idle_en && $urandom_range(99) < 16);
    end

    // Byte handshake. Called at a falling edge, returns at the falling edge
    // after the byte was taken, so push is assigned once per time step.
    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_en && $urandom_range(99) < 16) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // append one byte to the packet body being built
    task automatic add_byte(input logic [7:0] b);
        pkt_body.insert(pkt_body.size(), b);
    endtask

    // header (3-byte LE length, random sequence byte) then pkt_body
    task automatic send_body();
        logic [23:0] plen;
        plen = 24'(pkt_body.size());
        send_byte(plen[7:0]);
        send_byte(plen[15:8]);
        send_byte(plen[23:16]);
        send_byte(8'($urandom_range(255)));
        foreach (pkt_body[i]) send_byte(pkt_body[i]);
        pkt_body.delete();
    endtask

    task automatic send_pkt(input logic [7:0] lead, input int len);
        pkt_body.delete();
        if (len > 0) add_byte(lead);
        for (int i = 1; i < len; i++) add_byte(8'($urandom_range(255)));
        send_body();
    endtask

    // mostly short packets, a few up to 300 bytes to exercise the middle length byte
    function automatic int rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(6);
        if (r < 95) return $urandom_range(40, 7);
        return $urandom_range(300, 41);
    endfunction

    // Lead byte for a definition or row packet that must not end the response.
    // Markers are favored so the edges of the decode get hit often.
    function automatic logic [7:0] pick_lead(input bit in_rows, input int len);
        logic [7:0] b;
        bit         bad;
        do begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0:       b = MK_OK;
                    1:       b = MK_INFILE;
                    2:       b = MK_CNT2;
                    3:       b = MK_CNT3;
                    4:       b = MK_EOF;
                    default: b = MK_ERR;
                endcase
            end else begin
                b = 8'($urandom_range(255));
            end
            if (dep_mode)
                bad = in_rows && (b == MK_OK || b == MK_EOF || b == MK_ERR);
            else
                bad = (b == MK_ERR) || (b == MK_EOF && len <= SHORT_EOF_MAX);
        end while (bad);
        return b;
    endfunction

    task automatic send_filler(input bit in_rows, input bit bare);
        int len;
        len = bare ? 0 : rand_len();
        send_pkt(pick_lead(in_rows, len), len);
    endtask

    // single-packet responses
    task automatic send_first_end(input logic [2:0] kind);
        case (kind)
            END_EMPTY: send_pkt(MK_OK, 0);
            END_OK:    send_pkt(MK_OK, $urandom_range(8, 1));
            END_ERR:   send_pkt(MK_ERR, $urandom_range(8, 1));
            END_EOF:   send_pkt(MK_EOF, $urandom_range(SHORT_EOF_MAX, 1));
            default:   send_pkt(MK_INFILE, $urandom_range(8, 1));
        endcase
        responses++;
    endtask

    // Full result set. In legacy mode ndefs definitions go out before the
    // short EOF; in deprecate mode exactly the decoded count is sent.
    task automatic send_result_set(input logic [63:0] ncol, input t_enc enc,
                                   input int ndefs, input int nrows, input t_fin fin,
                                   input bit bare);
        logic [63:0] eff;
        int          fill;
        int          pick;
        eff = ncol;
        fill = $urandom_range(2);
        pkt_body.delete();
        case (enc)
            ENC_BYTE: add_byte(ncol[7:0]);
            ENC_WORD: begin
                add_byte(MK_CNT2);
                for (int i = 0; i < 2; i++) add_byte(ncol[8*i +: 8]);
            end
            ENC_TRIPLE: begin
                add_byte(MK_CNT3);
                for (int i = 0; i < 3; i++) add_byte(ncol[8*i +: 8]);
            end
            ENC_QUAD: begin
                add_byte(MK_EOF);
                for (int i = 0; i < 8; i++) add_byte(ncol[8*i +: 8]);
            end
            default: begin
                // truncated count: prefix promises more bytes than the packet holds
                eff  = '0;
                pick = $urandom_range(2);
                if (pick == 0) begin
                    add_byte(MK_CNT2);
                    fill = $urandom_range(1);
                end else if (pick == 1) begin
                    add_byte(MK_CNT3);
                    fill = $urandom_range(2);
                end else begin
                    add_byte(MK_EOF);
                    fill = $urandom_range(7, 5);
                end
            end
        endcase
        for (int i = 0; i < fill; i++) add_byte(8'($urandom_range(255)));
        send_body();

        if (!dep_mode) begin
            for (int i = 0; i < ndefs; i++) send_filler(1'b0, bare);
        end else begin
            for (logic [63:0] i = 0; i < eff; i++) send_filler(1'b0, bare);
        end

        if (!dep_mode && fin == FIN_ERR_DEFS) begin
            send_pkt(MK_ERR, $urandom_range(8, 1));
        end else begin
            if (!dep_mode) send_pkt(MK_EOF, $urandom_range(SHORT_EOF_MAX, 1));
            for (int i = 0; i < nrows; i++) send_filler(1'b1, bare);
            if (fin != FIN_DONE)
                send_pkt(MK_ERR, $urandom_range(8, 1));
            else if (!dep_mode)
                send_pkt(MK_EOF, $urandom_range(SHORT_EOF_MAX, 1));
            else
                send_pkt($urandom_range(1) ? MK_OK : MK_EOF, $urandom_range(8, 1));
        end
        responses++;
    endtask

    task automatic send_random_response();
        int          roll;
        t_enc        enc;
        t_fin        fin;
        logic [63:0] ncol;
        roll = $urandom_range(99);
        if (roll < 12) begin
            case ($urandom_range(4))
                0:       send_first_end(END_EMPTY);
                1:       send_first_end(END_OK);
                2:       send_first_end(END_ERR);
                3:       send_first_end(END_EOF);
                default: send_first_end(END_INFILE);
            endcase
        end else begin
            enc  = t_enc'($urandom_range(4));
            roll = $urandom_range(99);
            fin  = (roll < 75) ? FIN_DONE : (roll < 90) ? FIN_ERR_ROWS : FIN_ERR_DEFS;
            if (dep_mode) begin
                // counted definitions: keep the count small
                ncol = (enc == ENC_BYTE) ? 64'($urandom_range(6, 1))
                                         : 64'($urandom_range(6));
            end else begin
                case (enc)
                    ENC_BYTE:   ncol = 64'($urandom_range(250, 1));
                    ENC_WORD:   ncol = 64'($urandom_range(16'hFFFF));
                    ENC_TRIPLE: ncol = 64'($urandom_range(24'hFF_FFFF));
                    default:    ncol = {$urandom, $urandom};
                endcase
            end
            send_result_set(ncol, enc, $urandom_range(4),
                            ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5),
                            fin, $urandom_range(9) == 0);
        end
    endtask

    // hold the sender until every predicted end has come out, then let the
    // block finish any bytes that produce no result
    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // only written while drained
    task automatic write_mode(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        dep_mode     = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // ends the run if neither side moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("sql_response_end_tracker verification failed");
        $finish;
    end

    initial begin : stimulus
        int seg;
        int seg_start;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed, legacy framing ----
        write_mode(1'b0);
        send_first_end(END_EMPTY);
        send_first_end(END_OK);
        send_first_end(END_ERR);
        send_pkt(MK_EOF, 1);                    // shortest short EOF
        responses++;
        send_pkt(MK_EOF, SHORT_EOF_MAX);        // longest short EOF
        responses++;
        send_first_end(END_INFILE);
        send_result_set(64'd250, ENC_BYTE, 2, 3, FIN_DONE, 1'b0);     // largest 1-byte count
        send_result_set(64'hFFFF, ENC_WORD, 0, 0, FIN_DONE, 1'b0);
        send_result_set(64'hFF_FFFF, ENC_TRIPLE, 1, 1, FIN_ERR_ROWS, 1'b0);
        send_result_set({64{1'b1}}, ENC_QUAD, 1, 2, FIN_DONE, 1'b0);
        send_result_set(64'd0, ENC_CUT, 1, 1, FIN_ERR_DEFS, 1'b0);
        send_result_set(64'd1, ENC_BYTE, 2, 2, FIN_DONE, 1'b1);       // empty defs and rows
        wait_drained();

        // ---- directed, deprecate-EOF framing ----
        write_mode(1'b1);
        send_result_set(64'd3, ENC_BYTE, 0, 2, FIN_DONE, 1'b1);       // empty rows still count
        send_result_set(64'd0, ENC_WORD, 0, 2, FIN_DONE, 1'b0);       // no defs, straight to rows
        send_result_set(64'd0, ENC_CUT, 0, 1, FIN_ERR_ROWS, 1'b0);
        send_result_set(64'd2, ENC_QUAD, 0, 0, FIN_DONE, 1'b0);
        send_result_set(64'd1, ENC_TRIPLE, 0, 3, FIN_DONE, 1'b0);
        send_first_end(END_OK);
        send_first_end(END_ERR);
        send_first_end(END_EMPTY);
        wait_drained();

        // ---- random segments up to the byte budget; config changes only at drained points ----
        seg = 0;
        seg_start = bytes_sent;
        while (bytes_sent < TOTAL_BYTES) begin
            if (seg == 0)      write_mode(1'b0);
            else if (seg == 1) write_mode(1'b1);
            else               write_mode(1'($urandom_range(1)));
            // one segment runs with both sides streaming flat out
            tx_idle_en = (seg != 1);
            rx_idle_en = (seg != 1);
            while (bytes_sent - seg_start < (seg + 1) * SEG_BYTES &&
                   bytes_sent < TOTAL_BYTES)
                send_random_response();
            wait_drained();
            seg++;
        end

        $display("run covered %0d bytes in %0d responses over %0d random segments",
                 bytes_sent, responses, seg);
        $display("both framing modes, every end kind, cut and wide counts; %0d ends checked",
                 checked);
        if (fail_count == 0) begin
            $display("sql_response_end_tracker verification clean");
        end else begin
            $display("sql_response_end_tracker verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/sret_pkg.sv
hdl/sret_fifo.sv
hdl/sret_front.sv
hdl/sret_back.sv
hdl/sql_response_end_tracker.sv
tb/sql_response_end_tracker_checker.sv
tb/sql_response_end_tracker_tb.sv
